### src/tpe_pkg.sv
// shared types, constants and helpers of the transport-stream payload extractor
package tpe_pkg;

  localparam logic [7:0]  SYNC_BYTE    = 8'h47;
  localparam logic [7:0]  PKT_LAST     = 8'd187;
  localparam logic [8:0]  PKT_END      = 9'd188;
  localparam logic [8:0]  PES_HDR_LEN  = 9'd9;
  localparam logic [7:0]  PUSI_MASK    = 8'h40;
  localparam logic [7:0]  PID_HI_MASK  = 8'h1F;
  localparam logic [7:0]  ADP_MASK     = 8'h20;

  // prefix tracker codes: 0..3 bytes held, then skip and pass-through
  localparam logic [2:0]  MODE_SKIP    = 3'd4;
  localparam logic [2:0]  MODE_PASS    = 3'd5;

  // register indexes and reset values
  localparam logic        REG_PID      = 1'b0;
  localparam logic        REG_SID      = 1'b1;
  localparam logic [12:0] PID_RESET    = 13'd34;
  localparam logic [7:0]  SID_RESET    = 8'hC0;

  // results caused by one input byte
  typedef struct packed {
    logic       err;
    logic       tail_valid;
    logic [7:0] tail;
    logic [2:0] count;
  } bundle_t;

  // byte of the start-code prefix 00 00 01 <stream id> at index idx
  function automatic logic [7:0] held_value(input logic [1:0] idx, input logic [7:0] sid);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h00;
      2'd2:    v = 8'h01;
      default: v = sid;
    endcase
    return v;
  endfunction

endpackage

### src/tpe_cfg.sv
// configuration registers behind the apb-style port
module tpe_cfg
  import tpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [12:0] pid_o,
  output logic [7:0]  sid_o
);

  logic [12:0] pid_q;
  logic [7:0]  sid_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q <= PID_RESET;
      sid_q <= SID_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PID: pid_q <= pwdata[12:0];
        REG_SID: sid_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_PID: prdata = {19'd0, pid_q};
      REG_SID: prdata = {24'd0, sid_q};
      default: prdata = 32'd0;
    endcase
  end

  assign pid_o = pid_q;
  assign sid_o = sid_q;

endmodule

### src/tpe_parser.sv
// pkt header parser and prefix tracker; a byte per cycle into a free bundle register
module tpe_parser
  import tpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_start_i,
  input  logic [12:0] pid_i,
  input  logic [7:0]  sid_i,
  output logic        bnd_valid_o,
  input  logic        bnd_ready_i,
  output bundle_t     bnd_o
);

  logic [7:0]  pos_q, pos_d;
  logic [12:0] pid_q, pid_d;
  logic        usf_q, usf_d;
  logic        adp_q, adp_d;
  logic [8:0]  bs_q, bs_d;
  logic [2:0]  pmc_q, pmc_d;
  logic [8:0]  skip_q, skip_d;
  logic        halt_q, halt_d;
  logic        bvalid_q;
  bundle_t     bnd_q, res;

  logic        acc;
  logic [7:0]  c_pos;
  logic [12:0] c_pid;
  logic        c_usf, c_adp, c_halt;
  logic [8:0]  c_bs, c_skip, off, end_sum;
  logic [2:0]  c_pmc, pmc_w;
  logic        in_body;

  assign in_ready_o = !bvalid_q || bnd_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // a new buffer restarts the parser before the byte is looked at
  always_comb begin
    c_pos  = in_start_i ? 8'd0  : pos_q;
    c_pid  = in_start_i ? 13'd0 : pid_q;
    c_usf  = in_start_i ? 1'b0  : usf_q;
    c_adp  = in_start_i ? 1'b0  : adp_q;
    c_bs   = in_start_i ? 9'd0  : bs_q;
    c_pmc  = in_start_i ? 3'd0  : pmc_q;
    c_skip = in_start_i ? 9'd0  : skip_q;
    c_halt = in_start_i ? 1'b0  : halt_q;
  end

  assign off     = {1'b0, c_pos} - c_bs;
  assign in_body = ({1'b0, c_pos} >= c_bs);
  assign pmc_w   = (off == 9'd0) ? (c_usf ? 3'd0 : MODE_PASS) : c_pmc;
  assign end_sum = c_bs + PES_HDR_LEN + {1'b0, in_byte_i};

  // next state and results of the current byte
  always_comb begin
    pos_d  = c_pos;
    pid_d  = c_pid;
    usf_d  = c_usf;
    adp_d  = c_adp;
    bs_d   = c_bs;
    pmc_d  = c_pmc;
    skip_d = c_skip;
    halt_d = c_halt;
    res    = '{err: 1'b0, tail_valid: 1'b0, tail: in_byte_i, count: 3'd0};

    if (!c_halt) begin
      pos_d = (c_pos >= PKT_LAST) ? 8'd0 : c_pos + 8'd1;
      case (c_pos)
        8'd0: begin
          if (in_byte_i != SYNC_BYTE) begin
            res    = '{err: 1'b1, tail_valid: 1'b1, tail: 8'd0, count: 3'd1};
            halt_d = 1'b1;
            pos_d  = c_pos;
          end
        end
        8'd1: begin
          usf_d = |(in_byte_i & PUSI_MASK);
          pid_d = {in_byte_i[4:0], 8'd0};
        end
        8'd2: begin
          pid_d = {c_pid[12:8], in_byte_i};
        end
        8'd3: begin
          adp_d = |(in_byte_i & ADP_MASK);
          bs_d  = adp_d ? 9'd5 : 9'd4;
        end
        default: begin
          if (c_pos == 8'd4 && c_adp) begin
            bs_d = 9'd5 + {1'b0, in_byte_i};
          end else if (in_body && c_pid == pid_i) begin
            pmc_d = pmc_w;
            if (pmc_w < MODE_SKIP) begin
              if (in_byte_i == held_value(pmc_w[1:0], sid_i)) begin
                pmc_d = pmc_w + 3'd1;
                if (pmc_d == MODE_SKIP) begin
                  skip_d = PKT_END;
                end else if (c_pos == PKT_LAST) begin
                  // prefix cut by the packet end: flush held bytes
                  res.count = pmc_d;
                end
              end else begin
                res.count      = pmc_w + 3'd1;
                res.tail_valid = 1'b1;
                pmc_d          = MODE_PASS;
              end
            end else if (pmc_w == MODE_SKIP) begin
              if (off == PES_HDR_LEN - 9'd1) begin
                skip_d = (end_sum > PKT_END) ? PKT_END : end_sum;
              end else if (off >= PES_HDR_LEN && {1'b0, c_pos} >= c_skip) begin
                res.count      = 3'd1;
                res.tail_valid = 1'b1;
              end
            end else begin
              res.count      = 3'd1;
              res.tail_valid = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pid_q  <= '0;
      usf_q  <= 1'b0;
      adp_q  <= 1'b0;
      bs_q   <= '0;
      pmc_q  <= '0;
      skip_q <= '0;
      halt_q <= 1'b0;
    end else if (acc) begin
      pos_q  <= pos_d;
      pid_q  <= pid_d;
      usf_q  <= usf_d;
      adp_q  <= adp_d;
      bs_q   <= bs_d;
      pmc_q  <= pmc_d;
      skip_q <= skip_d;
      halt_q <= halt_d;
    end
  end

  // bundle register, holds only bytes that gave results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
    end else if (in_ready_o) begin
      bvalid_q <= acc && (res.count != 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      bnd_q <= res;
    end
  end

  assign bnd_valid_o = bvalid_q;
  assign bnd_o       = bnd_q;

endmodule

### src/tpe_out.sv
// output stage: sends a bundle's results one per cycle while m_ready_i is high
module tpe_out
  import tpe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       bnd_valid_i,
  output logic       bnd_ready_o,
  input  bundle_t    bnd_i,
  input  logic [7:0] sid_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] m_byte_o,
  output logic       m_last_o,
  output logic       m_err_o
);

  logic       valid_q;
  bundle_t    cur_q;
  logic [1:0] idx_q;
  logic       is_last;

  assign is_last     = ({1'b0, idx_q} == cur_q.count - 3'd1);
  assign bnd_ready_o = !valid_q || (m_ready_i && is_last);

  // load a new bundle or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (bnd_ready_o) begin
      valid_q <= bnd_valid_i;
      idx_q   <= '0;
    end else if (m_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_ready_o && bnd_valid_i) begin
      cur_q <= bnd_i;
    end
  end

  // the mismatching or passed byte closes the run, held prefix bytes come first
  assign m_valid_o = valid_q;
  assign m_byte_o  = (cur_q.tail_valid && is_last) ? cur_q.tail : held_value(idx_q, sid_i);
  assign m_last_o  = is_last;
  assign m_err_o   = cur_q.err;

endmodule

### src/ts_pes_payload_extractor.sv
// top level of the transport-stream pes payload extractor
//
//  channel   direction  fields
//  s_axis    in         tdata[7:0] data_byte, tuser starts_buffer
//  m_axis    out        tdata[7:0] payload_byte, tlast last_of_run, tuser sync_error
//  apb       in/out     0x0 selected_pid[12:0], 0x4 selected_stream_id[7:0]
//
// one input byte is taken per cycle unless the output backs up; its results land
// in a bundle register the cycle after and are sent one per cycle while the output
// is ready, so the next byte is already taken while they are sent.
// reset restores the register defaults and clears the parser; there is no
// clearing pass. a stalled output backs up through two bundle stages.
module ts_pes_payload_extractor
  import tpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] starts_buffer
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] payload_byte
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o,   // [0] sync_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] sel_pid;
  logic [7:0]  sel_sid;
  logic        bnd_valid, bnd_ready;
  bundle_t     bnd;

  tpe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pid_o   (sel_pid),
    .sid_o   (sel_sid)
  );

  tpe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_start_i  (s_axis_tuser_i),
    .pid_i       (sel_pid),
    .sid_i       (sel_sid),
    .bnd_valid_o (bnd_valid),
    .bnd_ready_i (bnd_ready),
    .bnd_o       (bnd)
  );

  tpe_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_valid_i (bnd_valid),
    .bnd_ready_o (bnd_ready),
    .bnd_i       (bnd),
    .sid_i       (sel_sid),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_byte_o    (m_axis_tdata_o),
    .m_last_o    (m_axis_tlast_o),
    .m_err_o     (m_axis_tuser_o)
  );

endmodule
